@@ hw/rtl/mdr_cmc_pkg.sv @@
// ----------------------------------------------------------------------------
// mdr_cmc_pkg
// shared types and constants for the confusion matrix classifier
// ----------------------------------------------------------------------------
package mdr_cmc_pkg;

   localparam int MAX_ORDER   = 4;
   localparam int ORDER_W     = 3;
   localparam int GENO_W      = 2;
   localparam int COUNT_W     = 16;
   localparam int INDEX_W     = COUNT_W + 1;
   localparam int TUPLE_W     = 7;
   localparam int MAP_LOW_W   = 64;
   localparam int MAP_HIGH_W  = 17;
   localparam int MAP_W       = MAP_LOW_W + MAP_HIGH_W;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;

   localparam logic [GENO_W-1:0]  MISSING_GENO      = 2'd3;
   localparam logic [ORDER_W-1:0] MODEL_ORDER_RESET = 3'd2;

   typedef logic [TUPLE_W-1:0] tuple_weight_type [MAX_ORDER];
   localparam tuple_weight_type GENO_WEIGHT = '{7'd1, 7'd3, 7'd9, 7'd27};

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MODEL_ORDER      = 3'd0,
      CSR_AFFECTED_COUNT   = 3'd1,
      CSR_UNAFFECTED_COUNT = 3'd2,
      CSR_RISKY_MAP_LOW    = 3'd3,
      CSR_RISKY_MAP_HIGH   = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [GENO_W-1:0] geno_0;
      logic [GENO_W-1:0] geno_1;
      logic [GENO_W-1:0] geno_2;
      logic [GENO_W-1:0] geno_3;
   } req_word_type;

   typedef struct packed {
      logic               predicted_risky;
      logic               sample_affected;
      logic               done_res;
      logic [COUNT_W-1:0] true_pos;
      logic [COUNT_W-1:0] false_neg;
      logic [COUNT_W-1:0] false_pos;
      logic [COUNT_W-1:0] true_neg;
   } rsp_word_type;

endpackage

@@ hw/rtl/mdr_confusion_matrix_classifier_top.sv @@
// ----------------------------------------------------------------------------
// mdr_confusion_matrix_classifier_top
// request words enter the input register; response words leave the result register
// throughput: one word per cycle, set by those registers, unless rsp_stall holds
// the bitmap lookup and counter update sit between those two registers
// reset: synchronous, active high; configuration registers return to their defaults
// (model order 2), the sample index and all four counters clear
// ----------------------------------------------------------------------------
module mdr_confusion_matrix_classifier_top
   import mdr_cmc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_word_type           req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_word_type           rsp_word,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic [ORDER_W-1:0]    model_order_ff;
   logic [COUNT_W-1:0]    affected_count_ff;
   logic [COUNT_W-1:0]    unaffected_count_ff;
   logic [MAP_LOW_W-1:0]  risky_map_low_ff;
   logic [MAP_HIGH_W-1:0] risky_map_high_ff;

   logic                  in_valid_ff, in_valid_in;
   req_word_type          in_word_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_word_type          rsp_word_ff, rsp_word_in;

   logic [INDEX_W-1:0]    sample_index_ff, sample_index_in;
   logic [COUNT_W-1:0]    tp_ff, tp_in, fn_ff, fn_in, fp_ff, fp_in, tn_ff, tn_in;

   logic                  accept;
   logic                  advance;
   logic [ORDER_W-1:0]    eff_order;
   logic [GENO_W-1:0]     geno [MAX_ORDER];
   logic [TUPLE_W-1:0]    tuple_idx;
   logic                  missing;
   logic                  risky;
   logic                  affected;
   logic                  done;
   logic [INDEX_W-1:0]    total;
   logic [MAP_W-1:0]      risky_map;

   // handshake
   assign advance     = in_valid_ff && !(rsp_valid_ff && rsp_stall);
   assign req_stall   = in_valid_ff && !advance;
   assign accept      = req_valid && !req_stall;
   assign in_valid_in = accept || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_word    = rsp_word_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         model_order_ff      <= MODEL_ORDER_RESET;
         affected_count_ff   <= '0;
         unaffected_count_ff <= '0;
         risky_map_low_ff    <= '0;
         risky_map_high_ff   <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_MODEL_ORDER:      model_order_ff      <= csr_wdata[ORDER_W-1:0];
            CSR_AFFECTED_COUNT:   affected_count_ff   <= csr_wdata[COUNT_W-1:0];
            CSR_UNAFFECTED_COUNT: unaffected_count_ff <= csr_wdata[COUNT_W-1:0];
            CSR_RISKY_MAP_LOW:    risky_map_low_ff    <= csr_wdata[MAP_LOW_W-1:0];
            CSR_RISKY_MAP_HIGH:   risky_map_high_ff   <= csr_wdata[MAP_HIGH_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // tuple index and bitmap lookup
   assign geno[0]   = in_word_ff.geno_0;
   assign geno[1]   = in_word_ff.geno_1;
   assign geno[2]   = in_word_ff.geno_2;
   assign geno[3]   = in_word_ff.geno_3;
   assign risky_map = {risky_map_high_ff, risky_map_low_ff};

   always_comb begin
      if (model_order_ff == '0) begin
         eff_order = ORDER_W'(1);
      end else if (model_order_ff > ORDER_W'(MAX_ORDER)) begin
         eff_order = ORDER_W'(MAX_ORDER);
      end else begin
         eff_order = model_order_ff;
      end
      missing   = 1'b0;
      tuple_idx = '0;
      for (int k = 0; k < MAX_ORDER; k++) begin
         if (ORDER_W'(k) < eff_order) begin
            if (geno[k] == MISSING_GENO) begin
               missing = 1'b1;
            end
            tuple_idx = tuple_idx + TUPLE_W'(TUPLE_W'(geno[k]) * GENO_WEIGHT[k]);
         end
      end
      risky = !missing && risky_map[tuple_idx];
   end

   // classification and running counts
   always_comb begin
      total    = INDEX_W'(affected_count_ff) + INDEX_W'(unaffected_count_ff);
      affected = sample_index_ff < INDEX_W'(affected_count_ff);
      done     = ({1'b0, sample_index_ff} + (INDEX_W+1)'(1)) >= {1'b0, total};

      tp_in = tp_ff;
      fn_in = fn_ff;
      fp_in = fp_ff;
      tn_in = tn_ff;
      if (affected && risky) begin
         tp_in = tp_ff + COUNT_W'(1);
      end else if (affected) begin
         fn_in = fn_ff + COUNT_W'(1);
      end else if (risky) begin
         fp_in = fp_ff + COUNT_W'(1);
      end else begin
         tn_in = tn_ff + COUNT_W'(1);
      end

      rsp_word_in.predicted_risky = risky;
      rsp_word_in.sample_affected = affected;
      rsp_word_in.done_res        = done;
      rsp_word_in.true_pos        = tp_in;
      rsp_word_in.false_neg       = fn_in;
      rsp_word_in.false_pos       = fp_in;
      rsp_word_in.true_neg        = tn_in;

      sample_index_in = sample_index_ff + INDEX_W'(1);
      if (done) begin
         sample_index_in = '0;
         tp_in           = '0;
         fn_in           = '0;
         fp_in           = '0;
         tn_in           = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         sample_index_ff <= '0;
         tp_ff           <= '0;
         fn_ff           <= '0;
         fp_ff           <= '0;
         tn_ff           <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            sample_index_ff <= sample_index_in;
            tp_ff           <= tp_in;
            fn_ff           <= fn_in;
            fp_ff           <= fp_in;
            tn_ff           <= tn_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         in_word_ff <= req_word;
      end
      if (advance) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

endmodule
